@@ rtl/core/rbe_pkg.sv @@
// Shared constants and controller/datapath types for the Rice byte encoder.
package rbe_pkg;

    localparam int SYMBOL_BITS_DEF = 8;
    localparam int KW              = 4;
    localparam logic [KW-1:0] RICE_K_RESET = 4'd2;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic slot_free;
    } t_stat;

endpackage

@@ rtl/core/rbe_item_if.sv @@
// Input item channel: function code and symbol.
interface rbe_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] symbol;

    modport source (output valid, output func, output symbol, input ready);
    modport sink   (input valid, input func, input symbol, output ready);
endinterface

@@ rtl/core/rbe_byte_if.sv @@
// Output item channel: packed code byte and last flag.
interface rbe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last;

    modport source (output valid, output code_byte, output last, input ready);
    modport sink   (input valid, input code_byte, input last, output ready);
endinterface

@@ rtl/core/rbe_ctrl.sv @@
// Controller state machine: accepts items and paces the packer steps.
module rbe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rbe_pkg::t_stat i_stat,
    output rbe_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready    = (r_state == S_IDLE);
    assign o_cmd.load = i_valid && (r_state == S_IDLE);
    assign o_cmd.step = (r_state == S_RUN) && !i_stat.empty && i_stat.slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.empty) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_step_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> i_stat.slot_free && !i_stat.empty)
        else $error("step issued without free slot or pending work");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_RUN)
        else $error("load did not start a run");

    a_no_step_and_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.step))
        else $error("load and step in the same cycle");

endmodule

@@ rtl/core/rbe_dp.sv @@
// Datapath: Rice code generator, MSB-first byte packer and output register.
module rbe_dp #(
    parameter int SYMBOL_BITS = rbe_pkg::SYMBOL_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rbe_pkg::t_cmd          i_cmd,
    output rbe_pkg::t_stat         o_stat,
    input  logic                   i_cfg_we,
    input  logic [rbe_pkg::KW-1:0] i_cfg_data,
    input  logic                   i_func,
    input  logic [7:0]             i_symbol,
    output logic                   o_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_code_byte,
    output logic                   o_last
);

    localparam int TW   = SYMBOL_BITS + 1;
    localparam int TMAX = (TW > 8) ? TW : 8;
    localparam int TLW  = $clog2(TMAX + 1);
    localparam int SBW  = $clog2(SYMBOL_BITS + 1);
    localparam int CW   = (SBW > rbe_pkg::KW) ? SBW : rbe_pkg::KW;

    logic [rbe_pkg::KW-1:0] r_k;
    logic [6:0]             r_bits;
    logic [2:0]             r_cnt;
    logic [7:0]             r_ones;
    logic [TW-1:0]          r_tail;
    logic [TLW-1:0]         r_tlen;
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_last;

    // load-time code setup
    logic [CW-1:0]          k_ext;
    logic [CW-1:0]          kk;
    logic [SYMBOL_BITS+7:0] sym_wide;
    logic [SYMBOL_BITS-1:0] sym_v;
    logic [SYMBOL_BITS-1:0] low_mask;
    logic [SYMBOL_BITS+7:0] q_wide;
    logic [TW-1:0]          tail_load;

    // packing step
    logic [8:0]    rem;
    logic [3:0]    need;
    logic [3:0]    take;
    logic [7:0]    win;
    logic [TW+7:0] tail_ext;
    logic [7:0]    acc;
    logic [7:0]    ones_take;
    logic [3:0]    tail_take;
    logic          full;
    logic [8:0]    rem_after;

    assign k_ext    = CW'(r_k);
    assign kk       = (k_ext > CW'(SYMBOL_BITS)) ? CW'(SYMBOL_BITS) : k_ext;
    assign sym_wide = {{SYMBOL_BITS{1'b0}}, i_symbol};
    assign sym_v    = sym_wide[SYMBOL_BITS-1:0];
    assign low_mask = ~({SYMBOL_BITS{1'b1}} << kk);
    assign q_wide   = {8'b0, sym_v} >> kk;
    assign tail_load = {1'b0, sym_v & low_mask} << (CW'(SYMBOL_BITS) - kk);

    assign rem      = 9'(r_ones) + 9'(r_tlen);
    assign need     = 4'd8 - {1'b0, r_cnt};
    assign take     = (rem < 9'(need)) ? rem[3:0] : need;
    assign tail_ext = {r_tail, 8'b0};

    always_comb begin
        for (int p = 0; p < 8; p++) begin
            if (8'(p) < r_ones) begin
                win[7-p] = 1'b1;
            end else begin
                win[7-p] = tail_ext[TW+7-(p-int'(r_ones))];
            end
        end
    end

    assign acc       = ({1'b0, r_bits} << take) | (win >> (4'd8 - take));
    assign ones_take = (8'(take) < r_ones) ? 8'(take) : r_ones;
    assign tail_take = take - ones_take[3:0];
    assign full      = (take == need);
    assign rem_after = rem - 9'(take);

    assign o_stat.empty     = (rem == 9'd0);
    assign o_stat.slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= rbe_pkg::RICE_K_RESET;
            r_bits      <= '0;
            r_cnt       <= '0;
            r_ones      <= '0;
            r_tail      <= '0;
            r_tlen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_k <= i_cfg_data;
            end
            if (i_cmd.step && full) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                if (i_func == rbe_pkg::FUNC_FLUSH) begin
                    // pad the partial byte with zeros
                    r_ones <= '0;
                    r_tail <= '0;
                    r_tlen <= (r_cnt != 3'd0) ? TLW'(need) : '0;
                end else begin
                    r_ones <= q_wide[7:0];
                    r_tail <= tail_load;
                    r_tlen <= TLW'(kk) + TLW'(1);
                end
            end else if (i_cmd.step) begin
                r_ones <= r_ones - ones_take;
                r_tail <= r_tail << tail_take;
                r_tlen <= r_tlen - TLW'(tail_take);
                if (full) begin
                    r_bits      <= '0;
                    r_cnt       <= '0;
                    r_out_byte  <= acc;
                    r_out_last  <= (rem_after < 9'd8);
                end else begin
                    r_bits <= acc[6:0];
                    r_cnt  <= r_cnt + take[2:0];
                end
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_code_byte = r_out_byte;
    assign o_last      = r_out_last;

    a_flush_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_func == rbe_pkg::FUNC_FLUSH) |=> rem < 9'd8)
        else $error("flush queued more than a byte of padding");

    a_full_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && full) |=> r_out_valid && r_cnt == 3'd0)
        else $error("full byte not moved to output");

    a_partial_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !full) |=> rem == 9'd0)
        else $error("partial byte left with code bits remaining");

endmodule

@@ rtl/core/rice_byte_encoder.sv @@
// Rice byte encoder top level: controller and datapath with item channels.
// Each encode item sends symbol>>k one bits, a zero bit and the k low symbol bits,
// packed MSB-first into bytes; every completed byte is an output item, the final
// one of an input item marked last. A flush item emits the pending partial byte
// zero-padded (nothing if none is pending) and clears the packer. The packer
// moves up to eight code bits per cycle while the output has a free slot. An item
// is loaded, then packed in ceil((pending bits + code bits) / 8) packer steps,
// with (symbol>>k) + k + 1 code bits for an encode item and none for a flush,
// after which the controller returns to idle; a step waits on a stalled output.
// A new item is taken once the previous one has finished packing, even while its
// last byte still waits at the output. rice_k above SYMBOL_BITS acts as SYMBOL_BITS.
module rice_byte_encoder #(
    parameter int SYMBOL_BITS = rbe_pkg::SYMBOL_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    rbe_item_if.sink               i_item,
    rbe_byte_if.source             o_code,
    input  logic                   i_cfg_we,
    input  logic [rbe_pkg::KW-1:0] i_cfg_data
);

    rbe_pkg::t_cmd  cmd;
    rbe_pkg::t_stat stat;

    rbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rbe_dp #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_item.func),
        .i_symbol    (i_item.symbol),
        .o_valid     (o_code.valid),
        .i_out_ready (o_code.ready),
        .o_code_byte (o_code.code_byte),
        .o_last      (o_code.last)
    );

endmodule

@@ tb/tb_rice_byte_encoder.sv @@
// Self-checking testbench for rice_byte_encoder: random traffic and stalls against a Rice predictor.
module tb_rice_byte_encoder;
    import rbe_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 28;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
    } t_code_item;

    class rice_byte_scoreboard;
        bit [KW-1:0] rice_k;
        bit [6:0]    pend_bits;
        bit [2:0]    pend_cnt;
        t_code_item  expected_bytes[$];
        int          errors;

        function new();
            rice_k    = RICE_K_RESET;
            pend_bits = '0;
            pend_cnt  = '0;
            errors    = 0;
        endfunction

        function void set_k(bit [KW-1:0] v);
            rice_k = v;
        endfunction

        function void pack_bit(bit b);
            bit [7:0]   acc;
            t_code_item ci;
            acc = {pend_bits, b};
            if (pend_cnt == 3'd7) begin
                ci.code_byte = acc;
                ci.last      = 1'b0;
                expected_bytes.push_back(ci);
                pend_bits = '0;
                pend_cnt  = '0;
            end else begin
                pend_bits = acc[6:0];
                pend_cnt  = pend_cnt + 3'd1;
            end
        endfunction

        // encode or flush one accepted item, queueing the bytes it produces
        function void note_item(bit f, bit [7:0] sym);
            int         kk;
            int         quot;
            int         n_before;
            bit [7:0]   padded;
            t_code_item ci;
            n_before = expected_bytes.size();
            if (f == FUNC_FLUSH) begin
                if (pend_cnt != 0) begin
                    padded       = {1'b0, pend_bits} << (8 - pend_cnt);
                    ci.code_byte = padded;
                    ci.last      = 1'b0;
                    expected_bytes.push_back(ci);
                end
                pend_bits = '0;
                pend_cnt  = '0;
            end else begin
                kk   = (rice_k > SYMBOL_BITS_DEF) ? SYMBOL_BITS_DEF : rice_k;
                quot = sym >> kk;
                for (int i = 0; i < quot; i++)
                    pack_bit(1'b1);
                pack_bit(1'b0);
                for (int i = kk; i > 0; i--)
                    pack_bit(sym[i-1]);
            end
            if (expected_bytes.size() > n_before)
                expected_bytes[expected_bytes.size()-1].last = 1'b1;
        endfunction

        function void check_byte(bit [7:0] code, bit last);
            t_code_item ci;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output item code_byte=%02h last=%0d",
                         $time, code, last);
                errors++;
            end else begin
                ci = expected_bytes.pop_front();
                if (ci.code_byte !== code) begin
                    $display("%0t: code_byte mismatch expected %02h actual %02h",
                             $time, ci.code_byte, code);
                    errors++;
                end
                if (ci.last !== last) begin
                    $display("%0t: last mismatch expected %0d actual %0d",
                             $time, ci.last, last);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [KW-1:0] i_cfg_data;

    rbe_item_if item_ch();
    rbe_byte_if code_ch();

    rice_byte_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_code     (code_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    rice_byte_scoreboard sb = new();

    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    function automatic int gap_len(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_item(input logic f, input logic [7:0] sym);
        int gap;
        gap = gap_len(gaps_on);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.func   <= f;
        item_ch.symbol <= sym;
        do
            @(posedge i_clk);
        while (!item_ch.ready);
        sb.note_item(f, sym);
    endtask

    task automatic encode(input logic [7:0] sym);
        send_item(FUNC_ENCODE, sym);
    endtask

    task automatic flush();
        send_item(FUNC_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rice_k(input logic [KW-1:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_k(v);
    endtask

    // output side: checks accepted bytes and drives ready with random stalls
    initial begin
        int stall_left;
        stall_left = 0;
        code_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (code_ch.valid && code_ch.ready)
                sb.check_byte(code_ch.code_byte, code_ch.last);
            if (hold_request) begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len(stalls_on);
            end
            if (!i_rst_n || stall_left > 0) begin
                code_ch.ready <= 1'b0;
                if (stall_left > 0)
                    stall_left--;
            end else begin
                code_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [KW-1:0] kv;
        int            kk;
        int            r;
        logic [7:0]    sym;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_data     <= '0;
        item_ch.valid  <= 1'b0;
        item_ch.func   <= FUNC_ENCODE;
        item_ch.symbol <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of k
        encode(8'h00);
        encode(8'hFF);
        flush();
        flush();
        encode(8'h03);
        flush();

        // k = 0: unary only, 255 fills the full output bound
        write_rice_k(4'd0);
        encode(8'hFF);
        encode(8'h00);
        encode(8'hFF);
        flush();

        write_rice_k(4'd8);
        encode(8'hA5);
        encode(8'hFF);
        flush();

        // out of range k clamps to eight
        write_rice_k(4'd15);
        encode(8'h5A);
        encode(8'h00);
        encode(8'h80);
        flush();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                kv = 4'd0;
            else if (p == 1)
                kv = 4'd8;
            else if ($urandom_range(0, 3) == 0)
                kv = KW'($urandom_range(9, 15));
            else
                kv = KW'($urandom_range(0, 8));
            write_rice_k(kv);
            kk        = (kv > SYMBOL_BITS_DEF) ? SYMBOL_BITS_DEF : kv;
            gaps_on   = (p % 3 != 2);
            stalls_on = (p % 4 != 1);
            if (p == 4) begin
                gaps_on      = 1'b0;
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    flush();
                end else begin
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        sym = 8'($urandom_range(0, ((4 << kk) > 256) ? 255 : (4 << kk) - 1));
                    else if (r < 9)
                        sym = 8'($urandom_range(0, 255));
                    else
                        sym = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    encode(sym);
                end
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
